### rtl/core/pavp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pavp_pkg
// widths, codes and constants of the two-range antoine vapor pressure core
// ----------------------------------------------------------------------------
package pavp_pkg;

   localparam int TEMP_W     = 16;
   localparam int PRES_W     = 24;
   localparam int STAT_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 19;
   localparam int A_W        = 19;
   localparam int B_W        = 17;
   localparam int C_W        = 14;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_COLD = 2'd1,
      STATUS_HOT  = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_A_LOW  = 3'd0,
      CSR_B_LOW  = 3'd1,
      CSR_C_LOW  = 3'd2,
      CSR_A_HIGH = 3'd3,
      CSR_B_HIGH = 3'd4,
      CSR_C_HIGH = 3'd5,
      CSR_SPLIT  = 3'd6
   } csr_index_type;

   // what the back end of the pipe does with an item
   typedef enum logic [1:0] {
      KIND_ZERO = 2'd0,
      KIND_MAX  = 2'd1,
      KIND_CALC = 2'd2
   } kind_type;

   localparam logic [TEMP_W-1:0] COLD_MAX_T = 16'd18438;
   localparam logic [TEMP_W-1:0] HOT_MIN_T  = 16'd32809;

   localparam logic [A_W-1:0]    A_LOW_RST  = 19'd341055;
   localparam logic [B_W-1:0]    B_LOW_RST  = 17'd101206;
   localparam logic [C_W-1:0]    C_LOW_RST  = 14'h3FFF & 14'(-2144);
   localparam logic [A_W-1:0]    A_HIGH_RST = 19'd338069;
   localparam logic [B_W-1:0]    B_HIGH_RST = 17'd100455;
   localparam logic [C_W-1:0]    C_HIGH_RST = 14'h3FFF & 14'(-2230);
   localparam logic [TEMP_W-1:0] SPLIT_RST  = 16'd22624;

   // divider: numerator b<<16 plus half the denominator, quotient below 2^21
   localparam int DEN_W     = 16;
   localparam int NUM_W     = 34;
   localparam int DIV_STEPS = 21;

   // decimal log in q16
   localparam int Y_W = 23;
   localparam logic signed [Y_W-1:0] Y_OFFSET = 23'sd327680;
   localparam logic signed [Y_W-1:0] Y_SAT    = 23'sd475136;
   localparam logic signed [Y_W-1:0] Y_ZERO   = -23'sd131072;
   localparam int Y2_W = 20;

   localparam int L2_W = 30;
   localparam logic [L2_W-1:0] LOG2_10 = 30'd891723283;
   localparam int W_W  = Y2_W + L2_W;
   localparam int E_W  = 5;
   localparam int F_W  = 30;

   localparam int HORNER_STEPS = 8;
   localparam int P_W          = 31;
   localparam logic [P_W-1:0] COEF_TOP = 31'd1419;

   function automatic logic [P_W-1:0] horner_coef(input int h);
      logic [P_W-1:0] c;
      case (h)
         0:       c = 31'd16378;
         1:       c = 31'd165394;
         2:       c = 31'd1431680;
         3:       c = 31'd10327388;
         4:       c = 31'd59597083;
         5:       c = 31'd257941248;
         6:       c = 31'd744261118;
         default: c = 31'd1073741824;
      endcase
      return c;
   endfunction

   // final rounding and divide by 100
   localparam int V_W = 32;
   localparam logic [V_W-1:0] ROUND_BIAS = 32'd50;
   localparam logic [V_W-1:0] V_SAT      = 32'd1677721600;
   localparam logic [V_W-1:0] RECIP_100  = 32'd1374389535;
   localparam int RECIP_SHIFT = 37;

endpackage

### rtl/core/piecewise_antoine_vapor_pressure_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_antoine_vapor_pressure_core
// saturation pressure 1e5 * 10^(a - b/(c+t)) with two coefficient sets
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  req     | req_valid, req_stall, req_temperature   | in (beat)
//  rsp     | rsp_valid, rsp_stall, rsp_pressure_pa,  | out (beat)
//          | rsp_range_status                        |
//  csr     | csr_write, csr_index, csr_data          | in
//
//  one beat enters per cycle unless the pipe is frozen; each result passes
//  through the 21-stage restoring divider and 8 horner multiply stages
//  the whole pipe advances together; rsp_stall on a waiting result freezes it
//  and raises req_stall in the same cycle
//  reset is synchronous and clears the valid bits and loads the coefficients
// ----------------------------------------------------------------------------
module piecewise_antoine_vapor_pressure_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [pavp_pkg::TEMP_W-1:0]         req_temperature,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pavp_pkg::PRES_W-1:0]         rsp_pressure_pa,
   output logic [pavp_pkg::STAT_W-1:0]         rsp_range_status,
   input  logic                                csr_write,
   input  logic [pavp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pavp_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int NDIV = pavp_pkg::DIV_STEPS;
   localparam int NH   = pavp_pkg::HORNER_STEPS;

   // ------------------------------------------------------------------
   // coefficient registers
   // ------------------------------------------------------------------
   logic [pavp_pkg::A_W-1:0]    a_low_ff, a_high_ff;
   logic [pavp_pkg::B_W-1:0]    b_low_ff, b_high_ff;
   logic [pavp_pkg::C_W-1:0]    c_low_ff, c_high_ff;
   logic [pavp_pkg::TEMP_W-1:0] split_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_low_ff  <= pavp_pkg::A_LOW_RST;
         b_low_ff  <= pavp_pkg::B_LOW_RST;
         c_low_ff  <= pavp_pkg::C_LOW_RST;
         a_high_ff <= pavp_pkg::A_HIGH_RST;
         b_high_ff <= pavp_pkg::B_HIGH_RST;
         c_high_ff <= pavp_pkg::C_HIGH_RST;
         split_ff  <= pavp_pkg::SPLIT_RST;
      end else if (csr_write) begin
         case (pavp_pkg::csr_index_type'(csr_index))
            pavp_pkg::CSR_A_LOW:  a_low_ff  <= csr_data[pavp_pkg::A_W-1:0];
            pavp_pkg::CSR_B_LOW:  b_low_ff  <= csr_data[pavp_pkg::B_W-1:0];
            pavp_pkg::CSR_C_LOW:  c_low_ff  <= csr_data[pavp_pkg::C_W-1:0];
            pavp_pkg::CSR_A_HIGH: a_high_ff <= csr_data[pavp_pkg::A_W-1:0];
            pavp_pkg::CSR_B_HIGH: b_high_ff <= csr_data[pavp_pkg::B_W-1:0];
            pavp_pkg::CSR_C_HIGH: c_high_ff <= csr_data[pavp_pkg::C_W-1:0];
            pavp_pkg::CSR_SPLIT:  split_ff  <= csr_data[pavp_pkg::TEMP_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // pipe advance: everything moves unless the output beat is held
   // ------------------------------------------------------------------
   logic adv;
   logic out_vld_ff;

   assign adv       = !(out_vld_ff && rsp_stall);
   assign req_stall = !adv;

   // ------------------------------------------------------------------
   // stage 0: range check, set select, denominator
   // ------------------------------------------------------------------
   logic                          s0_vld_ff;
   pavp_pkg::status_type          s0_status_ff, s0_status_in;
   logic                          s0_ok_ff, s0_ok_in;
   logic [pavp_pkg::A_W-1:0]      s0_a_ff, s0_a_in;
   logic [pavp_pkg::B_W-1:0]      s0_b_ff, s0_b_in;
   logic [pavp_pkg::DEN_W-1:0]    s0_den_ff, s0_den_in;
   logic                          upper;
   logic [pavp_pkg::C_W-1:0]      c_sel;
   logic signed [pavp_pkg::DEN_W:0] den_full;

   always_comb begin
      upper = req_temperature > split_ff;
      c_sel = upper ? c_high_ff : c_low_ff;
      s0_a_in = upper ? a_high_ff : a_low_ff;
      s0_b_in = upper ? b_high_ff : b_low_ff;
      den_full = $signed({1'b0, req_temperature})
               + $signed({{(pavp_pkg::DEN_W + 1 - pavp_pkg::C_W){c_sel[pavp_pkg::C_W-1]}},
                          c_sel});
      s0_den_in = den_full[pavp_pkg::DEN_W-1:0];
      if (req_temperature <= pavp_pkg::COLD_MAX_T) begin
         s0_status_in = pavp_pkg::STATUS_COLD;
      end else if (req_temperature >= pavp_pkg::HOT_MIN_T) begin
         s0_status_in = pavp_pkg::STATUS_HOT;
      end else begin
         s0_status_in = pavp_pkg::STATUS_OK;
      end
      // nonpositive denominator gives zero pressure with ok status
      s0_ok_in = (s0_status_in == pavp_pkg::STATUS_OK)
               && !den_full[pavp_pkg::DEN_W] && (den_full != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (adv) begin
         s0_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_status_ff <= s0_status_in;
         s0_ok_ff     <= s0_ok_in;
         s0_a_ff      <= s0_a_in;
         s0_b_ff      <= s0_b_in;
         s0_den_ff    <= s0_den_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 1 and divider: rounded (b<<16)/den, one quotient bit a stage
   // index 0 holds the numerator split into partial remainder and low bits
   // ------------------------------------------------------------------
   logic                          dv_vld_ff    [0:NDIV];
   pavp_pkg::status_type          dv_status_ff [0:NDIV];
   logic                          dv_ok_ff     [0:NDIV];
   logic [pavp_pkg::A_W-1:0]      dv_a_ff      [0:NDIV];
   logic [pavp_pkg::DEN_W-1:0]    dv_den_ff    [0:NDIV];
   logic [pavp_pkg::DEN_W-1:0]    dv_rem_ff    [0:NDIV];
   logic [NDIV-1:0]               dv_low_ff    [0:NDIV];
   logic [pavp_pkg::NUM_W-1:0]    num_in;

   assign num_in = {1'b0, s0_b_ff, 16'd0}
                 + {{(pavp_pkg::NUM_W - pavp_pkg::DEN_W + 1){1'b0}},
                    s0_den_ff[pavp_pkg::DEN_W-1:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_vld_ff[0] <= s0_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_status_ff[0] <= s0_status_ff;
         dv_ok_ff[0]     <= s0_ok_ff;
         dv_a_ff[0]      <= s0_a_ff;
         dv_den_ff[0]    <= s0_den_ff;
         dv_rem_ff[0]    <= pavp_pkg::DEN_W'(num_in[pavp_pkg::NUM_W-1:NDIV]);
         dv_low_ff[0]    <= num_in[NDIV-1:0];
      end
   end

   for (genvar k = 0; k < NDIV; k++) begin : g_div
      logic [pavp_pkg::DEN_W:0]   trial;
      logic [pavp_pkg::DEN_W:0]   diff;
      logic                       ge;

      always_comb begin
         trial = {dv_rem_ff[k], dv_low_ff[k][NDIV-1]};
         diff  = trial - {1'b0, dv_den_ff[k]};
         ge    = trial >= {1'b0, dv_den_ff[k]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dv_vld_ff[k+1] <= dv_vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_status_ff[k+1] <= dv_status_ff[k];
            dv_ok_ff[k+1]     <= dv_ok_ff[k];
            dv_a_ff[k+1]      <= dv_a_ff[k];
            dv_den_ff[k+1]    <= dv_den_ff[k];
            dv_rem_ff[k+1]    <= ge ? diff[pavp_pkg::DEN_W-1:0]
                                    : trial[pavp_pkg::DEN_W-1:0];
            dv_low_ff[k+1]    <= {dv_low_ff[k][NDIV-2:0], ge};
         end
      end
   end

   // ------------------------------------------------------------------
   // log stage: y = a - q + 5 in q16, saturate and underflow checks
   // ------------------------------------------------------------------
   logic                           y_vld_ff;
   pavp_pkg::status_type           y_status_ff;
   pavp_pkg::kind_type             y_kind_ff, y_kind_in;
   logic [pavp_pkg::Y2_W-1:0]      y_y2_ff, y_y2_in;
   logic signed [pavp_pkg::Y_W-1:0] y_val, y_shift;

   always_comb begin
      y_val = $signed({{(pavp_pkg::Y_W - pavp_pkg::A_W){1'b0}}, dv_a_ff[NDIV]})
            - $signed({{(pavp_pkg::Y_W - NDIV){1'b0}}, dv_low_ff[NDIV]})
            + pavp_pkg::Y_OFFSET;
      y_shift = y_val - pavp_pkg::Y_ZERO;
      y_y2_in = y_shift[pavp_pkg::Y2_W-1:0];
      if (!dv_ok_ff[NDIV]) begin
         y_kind_in = pavp_pkg::KIND_ZERO;
      end else if (y_val >= pavp_pkg::Y_SAT) begin
         y_kind_in = pavp_pkg::KIND_MAX;
      end else if (y_val < pavp_pkg::Y_ZERO) begin
         y_kind_in = pavp_pkg::KIND_ZERO;
      end else begin
         y_kind_in = pavp_pkg::KIND_CALC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         y_vld_ff <= 1'b0;
      end else if (adv) begin
         y_vld_ff <= dv_vld_ff[NDIV];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         y_status_ff <= dv_status_ff[NDIV];
         y_kind_ff   <= y_kind_in;
         y_y2_ff     <= y_y2_in;
      end
   end

   // ------------------------------------------------------------------
   // base change: w = y2 * log2(10), integer exponent and q30 fraction
   // ------------------------------------------------------------------
   logic                        hz_vld_ff    [0:NH];
   pavp_pkg::status_type        hz_status_ff [0:NH];
   pavp_pkg::kind_type          hz_kind_ff   [0:NH];
   logic [pavp_pkg::E_W-1:0]    hz_e_ff      [0:NH];
   logic [pavp_pkg::F_W-1:0]    hz_f_ff      [0:NH-1];
   logic [pavp_pkg::P_W-1:0]    hz_p_ff      [1:NH];
   logic [pavp_pkg::W_W-1:0]    w_prod;

   assign w_prod = pavp_pkg::W_W'(y_y2_ff) * pavp_pkg::W_W'(pavp_pkg::LOG2_10);

   always_ff @(posedge clock) begin
      if (reset) begin
         hz_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         hz_vld_ff[0] <= y_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hz_status_ff[0] <= y_status_ff;
         hz_kind_ff[0]   <= y_kind_ff;
         hz_e_ff[0]      <= w_prod[44 +: pavp_pkg::E_W];
         hz_f_ff[0]      <= w_prod[14 +: pavp_pkg::F_W];
      end
   end

   // ------------------------------------------------------------------
   // 2^f by horner, one truncating q30 multiply per stage
   // ------------------------------------------------------------------
   for (genvar h = 0; h < NH; h++) begin : g_horner
      logic [pavp_pkg::P_W-1:0]              p_cur;
      logic [pavp_pkg::P_W+pavp_pkg::F_W-1:0] prod;

      if (h == 0) begin : g_first
         assign p_cur = pavp_pkg::COEF_TOP;
      end else begin : g_next
         assign p_cur = hz_p_ff[h];
      end

      assign prod = (pavp_pkg::P_W + pavp_pkg::F_W)'(p_cur)
                  * (pavp_pkg::P_W + pavp_pkg::F_W)'(hz_f_ff[h]);

      always_ff @(posedge clock) begin
         if (reset) begin
            hz_vld_ff[h+1] <= 1'b0;
         end else if (adv) begin
            hz_vld_ff[h+1] <= hz_vld_ff[h];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            hz_status_ff[h+1] <= hz_status_ff[h];
            hz_kind_ff[h+1]   <= hz_kind_ff[h];
            hz_e_ff[h+1]      <= hz_e_ff[h];
            hz_p_ff[h+1]      <= pavp_pkg::horner_coef(h)
                               + prod[pavp_pkg::F_W +: pavp_pkg::P_W];
         end
      end

      if (h < NH - 1) begin : g_fwd
         always_ff @(posedge clock) begin
            if (adv) begin
               hz_f_ff[h+1] <= hz_f_ff[h];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // scale by 2^e, drop q30, add rounding bias for the divide by 100
   // ------------------------------------------------------------------
   logic                               sh_vld_ff;
   pavp_pkg::status_type               sh_status_ff;
   pavp_pkg::kind_type                 sh_kind_ff, sh_kind_in;
   logic [pavp_pkg::V_W-1:0]           sh_v_ff, sh_v_in;
   logic [pavp_pkg::P_W+pavp_pkg::F_W-1:0] scaled;

   always_comb begin
      scaled  = (pavp_pkg::P_W + pavp_pkg::F_W)'(hz_p_ff[NH]) << hz_e_ff[NH];
      sh_v_in = {1'b0, scaled[pavp_pkg::F_W +: pavp_pkg::P_W]} + pavp_pkg::ROUND_BIAS;
      if (hz_kind_ff[NH] == pavp_pkg::KIND_CALC && sh_v_in >= pavp_pkg::V_SAT) begin
         sh_kind_in = pavp_pkg::KIND_MAX;
      end else begin
         sh_kind_in = hz_kind_ff[NH];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sh_vld_ff <= 1'b0;
      end else if (adv) begin
         sh_vld_ff <= hz_vld_ff[NH];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sh_status_ff <= hz_status_ff[NH];
         sh_kind_ff   <= sh_kind_in;
         sh_v_ff      <= sh_v_in;
      end
   end

   // ------------------------------------------------------------------
   // divide by 100 through the reciprocal
   // ------------------------------------------------------------------
   logic                         mu_vld_ff;
   pavp_pkg::status_type         mu_status_ff;
   pavp_pkg::kind_type           mu_kind_ff;
   logic [2*pavp_pkg::V_W-1:0]   mu_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mu_vld_ff <= 1'b0;
      end else if (adv) begin
         mu_vld_ff <= sh_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mu_status_ff <= sh_status_ff;
         mu_kind_ff   <= sh_kind_ff;
         mu_prod_ff   <= (2*pavp_pkg::V_W)'(sh_v_ff) * (2*pavp_pkg::V_W)'(pavp_pkg::RECIP_100);
      end
   end

   // ------------------------------------------------------------------
   // output register
   // ------------------------------------------------------------------
   logic [pavp_pkg::PRES_W-1:0]  out_pres_ff, out_pres_in;
   pavp_pkg::status_type         out_status_ff;

   always_comb begin
      case (mu_kind_ff)
         pavp_pkg::KIND_MAX:  out_pres_in = '1;
         pavp_pkg::KIND_CALC: out_pres_in = mu_prod_ff[pavp_pkg::RECIP_SHIFT +: pavp_pkg::PRES_W];
         default:             out_pres_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= mu_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_pres_ff   <= out_pres_in;
         out_status_ff <= mu_status_ff;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_pressure_pa  = out_pres_ff;
   assign rsp_range_status = out_status_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_status != pavp_pkg::STATUS_OK |-> rsp_pressure_pa == '0)
      else $error("out of range temperature with nonzero pressure");

   a_log_kind: assert property (@(posedge clock) disable iff (reset)
      y_vld_ff && y_status_ff != pavp_pkg::STATUS_OK |-> y_kind_ff == pavp_pkg::KIND_ZERO)
      else $error("out of range item marked for evaluation");

   a_exp_bound: assert property (@(posedge clock) disable iff (reset)
      hz_vld_ff[0] && hz_kind_ff[0] == pavp_pkg::KIND_CALC |-> hz_e_ff[0] <= 5'd30)
      else $error("binary exponent out of bounds");

endmodule
